// ===== hw/rtl/tcch_pkg.sv =====
// Package for the tilt-compensated compass heading unit.
// Holds the register indexes, the CORDIC arctangent table and fixed-point constants.
package tcch_pkg;

    localparam int TableLen = 24;
    localparam logic signed [19:0] PiQ16 = 20'sd205887;
    localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
    localparam logic signed [19:0] GainQ16 = 20'sd39797;
    localparam logic signed [20:0] CdegToRadQ32 = 21'sd749613;
    localparam logic signed [29:0] RadToCdegQ16 = 30'sd375493620;

    localparam int unsigned ATAN_Q16 [TableLen] = '{
        51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    // Configuration register indexes, in register map order
    typedef enum logic [2:0] {
        REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z, REG_SCALE_Y,
        REG_SCALE_Z, REG_PITCH_TRIM, REG_ROLL_TRIM, REG_DECLINATION
    } t_reg;

    // Sine/cosine operands of one rotation cell
    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic               neg;
    } t_rot;

    // Vectoring operands; x and y are Q32 horizontal field terms
    typedef struct packed {
        logic signed [53:0] x;
        logic signed [53:0] y;
        logic signed [19:0] z;
        logic               zero;
        logic               yneg;
    } t_vec;

endpackage

// ===== hw/rtl/tcch_rot_cell.sv =====
// One CORDIC rotation cell: advances sine/cosine by one micro-rotation.
// Depends on tcch_pkg.
module tcch_rot_cell #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  tcch_pkg::t_rot  i_d,
    output tcch_pkg::t_rot  o_q
);

    localparam logic signed [19:0] Atan = 20'(tcch_pkg::ATAN_Q16[STAGE]);

    tcch_pkg::t_rot r_q;
    tcch_pkg::t_rot n_q;

    always_comb begin
        n_q = i_d;
        if (!i_d.z[19]) begin
            n_q.x = i_d.x - (i_d.y >>> STAGE);
            n_q.y = i_d.y + (i_d.x >>> STAGE);
            n_q.z = i_d.z - Atan;
        end else begin
            n_q.x = i_d.x + (i_d.y >>> STAGE);
            n_q.y = i_d.y - (i_d.x >>> STAGE);
            n_q.z = i_d.z + Atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hw/rtl/tcch_vec_cell.sv =====
// One CORDIC vectoring cell: drives y toward zero and accumulates the angle.
// Depends on tcch_pkg.
module tcch_vec_cell #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  tcch_pkg::t_vec  i_d,
    output tcch_pkg::t_vec  o_q
);

    localparam logic signed [19:0] Atan = 20'(tcch_pkg::ATAN_Q16[STAGE]);

    tcch_pkg::t_vec r_q;
    tcch_pkg::t_vec n_q;

    always_comb begin
        n_q = i_d;
        if (!i_d.y[53] && (i_d.y != '0)) begin
            n_q.x = i_d.x + (i_d.y >>> STAGE);
            n_q.y = i_d.y - (i_d.x >>> STAGE);
            n_q.z = i_d.z + Atan;
        end else begin
            n_q.x = i_d.x - (i_d.y >>> STAGE);
            n_q.y = i_d.y + (i_d.x >>> STAGE);
            n_q.z = i_d.z - Atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hw/rtl/tilt_compensated_compass_heading_unit.sv =====
// Top level of the tilt-compensated compass heading unit.
// Depends on tcch_pkg, tcch_rot_cell and tcch_vec_cell.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  sample  | i_valid, o_ready, i_raw_x/y/z, i_pitch/roll| in
//  heading | o_valid, i_ready, o_heading               | out
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data           | in
//
// One item enters per cycle while the pipe is not held. An item passes
// the offset, scale and angle reduction stages, CORDIC_STAGES rotation
// cells, the product stages, CORDIC_STAGES vectoring cells and the output
// stages. The whole pipe advances together; it holds while the output
// register is full and not taken. Reset is synchronous; it clears the valid
// bits and loads the configuration registers with their defaults only.
module tilt_compensated_compass_heading_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_raw_x,
    input  logic signed [15:0] i_raw_y,
    input  logic signed [15:0] i_raw_z,
    input  logic signed [15:0] i_pitch,
    input  logic signed [15:0] i_roll,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [15:0] o_heading,
    input  logic               i_cfg_we,
    input  logic         [2:0] i_cfg_idx,
    input  logic        [15:0] i_cfg_data
);

    localparam int NS = (CORDIC_STAGES > tcch_pkg::TableLen) ?
                        tcch_pkg::TableLen : CORDIC_STAGES;
    // front 4 + rotation NS + products 2 + vectoring NS + back 2
    localparam int Depth = 2 * NS + 8;

    // configuration registers
    logic signed [15:0] r_off_x, r_off_y, r_off_z, r_decl;
    logic        [15:0] r_scl_y, r_scl_z;
    logic signed [10:0] r_ptrim, r_rtrim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
            r_scl_y <= 16'd4096;
            r_scl_z <= 16'd4096;
            r_ptrim <= 11'sd300;
            r_rtrim <= 11'sd200;
            r_decl  <= 16'sd500;
        end else if (i_cfg_we) begin
            unique case (tcch_pkg::t_reg'(i_cfg_idx))
                tcch_pkg::REG_OFFSET_X:    r_off_x <= i_cfg_data;
                tcch_pkg::REG_OFFSET_Y:    r_off_y <= i_cfg_data;
                tcch_pkg::REG_OFFSET_Z:    r_off_z <= i_cfg_data;
                tcch_pkg::REG_SCALE_Y:     r_scl_y <= i_cfg_data;
                tcch_pkg::REG_SCALE_Z:     r_scl_z <= i_cfg_data;
                tcch_pkg::REG_PITCH_TRIM:  r_ptrim <= i_cfg_data[10:0];
                tcch_pkg::REG_ROLL_TRIM:   r_rtrim <= i_cfg_data[10:0];
                tcch_pkg::REG_DECLINATION: r_decl  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: every stage moves when the output slot frees up.
    logic             en;
    logic [Depth-1:0] r_vld;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[Depth-1];

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7fff;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Stage 1: offsets, angle plus trim
    logic signed [15:0] r1_x, r1_y, r1_z;
    logic signed [16:0] r1_pa, r1_ra;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x  <= sat16(18'(i_raw_x) + 18'(r_off_x));
            r1_y  <= sat16(18'(i_raw_y) + 18'(r_off_y));
            r1_z  <= sat16(18'(i_raw_z) + 18'(r_off_z));
            r1_pa <= 17'(i_pitch) + 17'(r_ptrim);
            r1_ra <= 17'(i_roll) + 17'(r_rtrim);
        end
    end

    // Wrap into [-18000,18000); fold() below then folds into +-9000 with a sign flag.
    function automatic logic signed [15:0] wrap180(input logic signed [16:0] a);
        logic signed [17:0] r;
        r = 18'(a);
        if (r >= 18'sd18000) begin
            r = r - 18'sd36000;
        end else if (r < -18'sd18000) begin
            r = r + 18'sd36000;
        end
        return r[15:0];
    endfunction

    // Stage 2: soft-iron products, angle wrap
    logic signed [32:0] r2_py, r2_pz;
    logic signed [15:0] r2_x;
    logic signed [15:0] r2_pa, r2_ra;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_py <= 33'(r1_y) * $signed({1'b0, r_scl_y});
            r2_pz <= 33'(r1_z) * $signed({1'b0, r_scl_z});
            r2_x  <= r1_x;
            r2_pa <= wrap180(r1_pa);
            r2_ra <= wrap180(r1_ra);
        end
    end

    function automatic logic signed [15:0] scale_trunc(input logic signed [32:0] p);
        logic        [32:0] m;
        logic signed [32:0] q;
        m = p[32] ? 33'(-p) : p;
        m = m >> 12;
        q = p[32] ? -$signed(m) : $signed(m);
        if (q > 33'sd32767) begin
            return 16'sh7fff;
        end else if (q < -33'sd32768) begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

    function automatic logic signed [15:0] fold(input logic signed [15:0] r,
                                                output logic neg);
        neg = 1'b0;
        if (r > 16'sd9000) begin
            neg = 1'b1;
            return r - 16'sd18000;
        end else if (r < -16'sd9000) begin
            neg = 1'b1;
            return r + 16'sd18000;
        end
        return r;
    endfunction

    // Stage 3: scale saturation, fold, radian product
    logic signed [15:0] r3_x, r3_y, r3_z;
    logic signed [36:0] r3_pz, r3_rz;
    logic               r3_pn, r3_rn;
    logic signed [15:0] pf, rf;
    logic               pn, rn;

    always_comb begin
        pf = fold(r2_pa, pn);
        rf = fold(r2_ra, rn);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_x  <= r2_x;
            r3_y  <= scale_trunc(r2_py);
            r3_z  <= scale_trunc(r2_pz);
            r3_pz <= 37'(pf) * 37'(tcch_pkg::CdegToRadQ32) + 37'sd32768;
            r3_rz <= 37'(rf) * 37'(tcch_pkg::CdegToRadQ32) + 37'sd32768;
            r3_pn <= pn;
            r3_rn <= rn;
        end
    end

    function automatic logic signed [19:0] clampz(input logic signed [36:0] v);
        logic signed [20:0] z;
        z = v[36:16];
        if (z > 21'(tcch_pkg::HalfPiQ16)) begin
            return tcch_pkg::HalfPiQ16;
        end else if (z < -21'(tcch_pkg::HalfPiQ16)) begin
            return -tcch_pkg::HalfPiQ16;
        end
        return z[19:0];
    endfunction

    // Stage 4: seed both rotation chains, delay axes alongside
    tcch_pkg::t_rot r4_p, r4_r;
    logic signed [15:0] r4_x, r4_y, r4_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_p <= '{x: tcch_pkg::GainQ16, y: '0, z: clampz(r3_pz), neg: r3_pn};
            r4_r <= '{x: tcch_pkg::GainQ16, y: '0, z: clampz(r3_rz), neg: r3_rn};
            r4_x <= r3_x;
            r4_y <= r3_y;
            r4_z <= r3_z;
        end
    end

    // Rotation cell rows for pitch and roll; axes ride a matching shift line.
    tcch_pkg::t_rot p_ch [NS+1];
    tcch_pkg::t_rot r_ch [NS+1];
    logic signed [47:0] r_ax [NS];
    logic signed [47:0] ax_out;

    assign p_ch[0] = r4_p;
    assign r_ch[0] = r4_r;

    for (genvar g = 0; g < NS; g++) begin : g_rot
        tcch_rot_cell #(.STAGE(g)) u_p (
            .i_clk(i_clk), .i_en(en), .i_d(p_ch[g]), .o_q(p_ch[g+1]));
        tcch_rot_cell #(.STAGE(g)) u_r (
            .i_clk(i_clk), .i_en(en), .i_d(r_ch[g]), .o_q(r_ch[g+1]));
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ax[g] <= (g == 0) ? {r4_x, r4_y, r4_z} : r_ax[(g == 0) ? 0 : g-1];
            end
        end
    end
    assign ax_out = r_ax[NS-1];

    // Final sine/cosine with fold sign applied
    logic signed [19:0] sp, cp, sr, cr;
    assign sp = p_ch[NS].neg ? -p_ch[NS].y : p_ch[NS].y;
    assign cp = p_ch[NS].neg ? -p_ch[NS].x : p_ch[NS].x;
    assign sr = r_ch[NS].neg ? -r_ch[NS].y : r_ch[NS].y;
    assign cr = r_ch[NS].neg ? -r_ch[NS].x : r_ch[NS].x;

    // Product stage A: one multiply per product
    logic signed [15:0] ax, ay, az;
    assign ax = ax_out[47:32];
    assign ay = ax_out[31:16];
    assign az = ax_out[15:0];

    logic signed [36:0] r5_xcp, r5_ysr, r5_zcr, r5_ycr, r5_zsr;
    logic signed [19:0] r5_sp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_xcp <= 37'(ax) * 37'(cp);
            r5_ysr <= 37'(ay) * 37'(sr);
            r5_zcr <= 37'(az) * 37'(cr);
            r5_ycr <= 37'(ay) * 37'(cr);
            r5_zsr <= 37'(az) * 37'(sr);
            r5_sp  <= sp;
        end
    end

    // Product stage B: horizontal components in Q32
    tcch_pkg::t_vec r6_v;
    logic signed [53:0] hx, hy;
    logic signed [37:0] dsr;

    always_comb begin
        dsr = 38'(r5_ysr) - 38'(r5_zcr);
        hx  = (54'(r5_xcp) <<< 16) + 54'(dsr) * 54'(r5_sp);
        hy  = (54'(r5_ycr) + 54'(r5_zsr)) <<< 16;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_v.zero <= (hx == '0) && (hy == '0);
            r6_v.yneg <= hy[53];
            if (hx[53]) begin
                r6_v.x <= -hx;
                r6_v.y <= -hy;
                r6_v.z <= hy[53] ? -tcch_pkg::PiQ16 : tcch_pkg::PiQ16;
            end else begin
                r6_v.x <= hx;
                r6_v.y <= hy;
                r6_v.z <= '0;
            end
        end
    end

    tcch_pkg::t_vec v_ch [NS+1];
    assign v_ch[0] = r6_v;

    for (genvar g = 0; g < NS; g++) begin : g_vec
        tcch_vec_cell #(.STAGE(g)) u_v (
            .i_clk(i_clk), .i_en(en), .i_d(v_ch[g]), .o_q(v_ch[g+1]));
    end

    // Back stage 1: radians to centidegrees
    logic signed [50:0] r7_cd;
    logic               r7_yneg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_cd   <= v_ch[NS].zero ? '0 :
                       51'(v_ch[NS].z) * 51'(tcch_pkg::RadToCdegQ16) + (51'sd1 <<< 31);
            r7_yneg <= v_ch[NS].yneg;
        end
    end

    // Back stage 2: quadrant, negate, declination and wrap into [0,36000)
    logic signed [19:0] cd, h, hn;
    always_comb begin
        cd = 20'(r7_cd >>> 32);
        h  = r7_yneg ? cd + 20'sd36000 : cd;
        hn = -h - 20'(r_decl);
        while_wrap: begin
            if (hn < -20'sd36000) begin
                hn = hn + 20'sd72000;
            end else if (hn < 20'sd0) begin
                hn = hn + 20'sd36000;
            end
            if (hn >= 20'sd36000) begin
                hn = hn - 20'sd36000;
            end
        end
    end

    logic [15:0] r_heading;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_heading <= hn[15:0];
        end
    end
    assign o_heading = r_heading;

endmodule

// ===== bench/tilt_compensated_compass_heading_unit_test.sv =====
// Self-checking bench for tilt_compensated_compass_heading_unit.
// Predicts each heading with its own fixed-point model; depends on tcch_pkg and the RTL.
`timescale 1ns / 100ps

module tilt_compensated_compass_heading_unit_test;

    localparam int Stages   = 16;
    localparam int Latency  = Stages * 2 + 8;
    localparam int MaxCycle = 400000;

    typedef struct {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } t_sample;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_raw_x = '0, i_raw_y = '0, i_raw_z = '0;
    logic signed [15:0] i_pitch = '0, i_roll = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic        [15:0] o_heading;
    logic               i_cfg_we = 1'b0;
    logic         [2:0] i_cfg_idx = '0;
    logic        [15:0] i_cfg_data = '0;

    // Shadow copy of the configuration registers
    logic signed [15:0] off_x, off_y, off_z, decl;
    logic        [15:0] scl_y, scl_z;
    logic signed [10:0] trim_p, trim_r;

    logic [15:0] headings_due[$];
    int          errors = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          no_idle = 1'b0;
    bit          out_taken = 1'b0;

    tilt_compensated_compass_heading_unit #(.CORDIC_STAGES(Stages)) DUT (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Heading predictor
    // ---------------------------------------------------------------
    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Q4.12 soft-iron scale, product truncated toward zero
    function automatic longint soft_iron(longint v, logic [15:0] sc);
        longint p;
        p = v * longint'(sc);
        p = (p >= 0) ? (p >>> 12) : -((-p) >>> 12);
        return sat16(p);
    endfunction

    // Sine and cosine in Q16 of an angle in centidegrees
    function automatic void rotate(longint a, output longint s, output longint c);
        longint r, x, y, z, dx, dy;
        bit flip;
        r = a % 36000;
        flip = 1'b0;
        if (r < 0) r += 36000;
        if (r >= 18000) r -= 36000;
        // fold into the right half-plane and flip the sign afterwards
        if (r > 9000) begin
            r -= 18000;
            flip = 1'b1;
        end else if (r < -9000) begin
            r += 18000;
            flip = 1'b1;
        end
        z = (r * longint'(tcch_pkg::CdegToRadQ32) + 32768) >>> 16;
        if (z > tcch_pkg::HalfPiQ16) z = tcch_pkg::HalfPiQ16;
        if (z < -tcch_pkg::HalfPiQ16) z = -tcch_pkg::HalfPiQ16;
        x = tcch_pkg::GainQ16;
        y = 0;
        for (int i = 0; i < Stages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(tcch_pkg::ATAN_Q16[i]);
            end else begin
                x += dx; y -= dy; z += longint'(tcch_pkg::ATAN_Q16[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // Angle of (x, y) in Q16 radians; zero when the vector is zero
    function automatic longint bearing(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(tcch_pkg::PiQ16) : -longint'(tcch_pkg::PiQ16);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < Stages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(tcch_pkg::ATAN_Q16[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(tcch_pkg::ATAN_Q16[i]);
            end
        end
        return z;
    endfunction

    function automatic logic [15:0] heading_of(t_sample s);
        longint x, y, z, sp, cp, sr, cr, hx, hy, cd, h;
        x = sat16(longint'(s.raw_x) + longint'(off_x));
        y = soft_iron(sat16(longint'(s.raw_y) + longint'(off_y)), scl_y);
        z = soft_iron(sat16(longint'(s.raw_z) + longint'(off_z)), scl_z);
        rotate(longint'(s.pitch) + longint'(trim_p), sp, cp);
        rotate(longint'(s.roll) + longint'(trim_r), sr, cr);
        // horizontal field in Q32
        hx = x * cp * 65536 + y * sr * sp - z * cr * sp;
        hy = (y * cr + z * sr) * 65536;
        cd = (bearing(hy, hx) * longint'(tcch_pkg::RadToCdegQ16) + (longint'(1) << 31))
             >>> 32;
        h = (hy < 0) ? 36000 + cd : cd;
        h = (-h - longint'(decl)) % 36000;
        if (h < 0) h += 36000;
        return h[15:0];
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        errors++;
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // ---------------------------------------------------------------
    // Heading side: random back-pressure and checking
    // ---------------------------------------------------------------
    // Outputs are sampled at the falling edge, where every input is settled
    always @(negedge i_clk) begin
        out_taken <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (headings_due.size() == 0) begin
                report_mismatch("heading with no sample pending", 0, o_heading);
            end else begin
                logic [15:0] due;
                due = headings_due.pop_front();
                if (o_heading !== due) report_mismatch("heading", due, o_heading);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MaxCycle) begin
            $display("FAILURE");
            $finish;
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= i_rst_n;
            // after an item leaves, draw the stall before the next one
            if (out_taken && !no_idle) stall_left <= $urandom_range(0, 9);
        end
    end

    // ---------------------------------------------------------------
    // Sample side; every task starts and ends just after a rising edge
    // ---------------------------------------------------------------
    task automatic send_sample(t_sample s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_x <= s.raw_x;
        i_raw_y <= s.raw_y;
        i_raw_z <= s.raw_z;
        i_pitch <= s.pitch;
        i_roll  <= s.roll;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        headings_due.push_back(heading_of(s));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (headings_due.size() != 0) @(posedge i_clk);
        repeat (Latency) @(posedge i_clk);
    endtask

    // Write one register; the bench copy keeps only the register's width
    task automatic write_reg(tcch_pkg::t_reg idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            tcch_pkg::REG_OFFSET_X:    off_x  = data;
            tcch_pkg::REG_OFFSET_Y:    off_y  = data;
            tcch_pkg::REG_OFFSET_Z:    off_z  = data;
            tcch_pkg::REG_SCALE_Y:     scl_y  = data;
            tcch_pkg::REG_SCALE_Z:     scl_z  = data;
            tcch_pkg::REG_PITCH_TRIM:  trim_p = data[10:0];
            tcch_pkg::REG_ROLL_TRIM:   trim_r = data[10:0];
            tcch_pkg::REG_DECLINATION: decl   = data;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_sample sample_of(int x, int y, int z, int p, int r);
        t_sample s;
        s.raw_x = 16'(x); s.raw_y = 16'(y); s.raw_z = 16'(z);
        s.pitch = 16'(p); s.roll = 16'(r);
        return s;
    endfunction

    function automatic t_sample any_sample();
        t_sample s;
        s.raw_x = 16'($urandom);
        s.raw_y = 16'($urandom);
        s.raw_z = 16'($urandom);
        // mostly real attitudes, some beyond half a turn to hit the wrap
        if ($urandom_range(0, 3) == 0) begin
            s.pitch = 16'($urandom);
            s.roll  = 16'($urandom);
        end else begin
            s.pitch = 16'($urandom_range(0, 36000) - 18000);
            s.roll  = 16'($urandom_range(0, 36000) - 18000);
        end
        return s;
    endfunction

    // offset draw: full range or a small spread around zero
    function automatic logic [15:0] offset_draw(bit wide);
        return wide ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset values: level and tilted samples, and a zero field
    task automatic test_reset_values();
        send_sample(sample_of(0, 0, 0, 0, 0));
        send_sample(sample_of(1000, 0, 0, 0, 0));
        send_sample(sample_of(0, 1000, 0, 0, 0));
        send_sample(sample_of(-1000, -1000, 500, 4500, -4500));
        send_sample(sample_of(200, -300, 400, 9000, 9000));
        drain();
    endtask

    // Field extremes, angles past half a turn and saturation
    task automatic test_extremes();
        write_reg(tcch_pkg::REG_OFFSET_X, 16'h7fff);
        write_reg(tcch_pkg::REG_OFFSET_Y, 16'h8000);
        write_reg(tcch_pkg::REG_SCALE_Y, 16'hffff);
        write_reg(tcch_pkg::REG_SCALE_Z, 16'h0000);
        write_reg(tcch_pkg::REG_PITCH_TRIM, 16'd1000);
        write_reg(tcch_pkg::REG_ROLL_TRIM, -16'sd1000);
        write_reg(tcch_pkg::REG_DECLINATION, 16'd18000);
        send_sample(sample_of(32767, -32768, 32767, 18000, -18000));
        send_sample(sample_of(-32768, 32767, -32768, -18000, 18000));
        send_sample(sample_of(32767, 32767, 32767, 32767, -32768));
        send_sample(sample_of(-32768, -32768, -32768, -32768, 32767));
        send_sample(sample_of(-1, 1, -1, 9000, -9000));
        drain();
        write_reg(tcch_pkg::REG_OFFSET_X, 16'h8000);
        write_reg(tcch_pkg::REG_OFFSET_Y, 16'h0000);
        write_reg(tcch_pkg::REG_OFFSET_Z, 16'h7fff);
        write_reg(tcch_pkg::REG_SCALE_Y, 16'h0000);
        write_reg(tcch_pkg::REG_SCALE_Z, 16'hffff);
        write_reg(tcch_pkg::REG_PITCH_TRIM, 16'h03ff);
        write_reg(tcch_pkg::REG_ROLL_TRIM, 16'h0400);
        write_reg(tcch_pkg::REG_DECLINATION, -16'sd18000);
        send_sample(sample_of(32767, 100, -32768, 0, 0));
        send_sample(sample_of(-32768, -100, 32767, 17999, -17999));
        send_sample(sample_of(32768 - 1, 0, 0, -27000, 27000));
        drain();
        // full 16-bit declination, heading still wraps into range
        write_reg(tcch_pkg::REG_OFFSET_X, 16'h0000);
        write_reg(tcch_pkg::REG_OFFSET_Z, 16'h0000);
        write_reg(tcch_pkg::REG_SCALE_Y, 16'd4096);
        write_reg(tcch_pkg::REG_SCALE_Z, 16'd4096);
        write_reg(tcch_pkg::REG_PITCH_TRIM, 16'h0000);
        write_reg(tcch_pkg::REG_ROLL_TRIM, 16'h0000);
        write_reg(tcch_pkg::REG_DECLINATION, 16'h8000);
        send_sample(sample_of(0, 0, 0, 0, 0));
        send_sample(sample_of(-500, 20, 0, 0, 0));
        send_sample(sample_of(-500, -20, 0, 0, 0));
        drain();
        write_reg(tcch_pkg::REG_DECLINATION, 16'h7fff);
        send_sample(sample_of(300, 300, 300, 1000, -1000));
        send_sample(sample_of(-300, 0, 0, 0, 0));
        drain();
    endtask

    // Random samples over several random and extreme settings
    task automatic test_random_samples();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                write_reg(tcch_pkg::REG_OFFSET_X, 16'h8000);
                write_reg(tcch_pkg::REG_OFFSET_Y, 16'h7fff);
                write_reg(tcch_pkg::REG_OFFSET_Z, 16'h8000);
                write_reg(tcch_pkg::REG_SCALE_Y, 16'hffff);
                write_reg(tcch_pkg::REG_SCALE_Z, 16'hffff);
                write_reg(tcch_pkg::REG_PITCH_TRIM, 16'h0400);
                write_reg(tcch_pkg::REG_ROLL_TRIM, 16'h03ff);
                write_reg(tcch_pkg::REG_DECLINATION, 16'h8000);
            end else if (phase > 0) begin
                // offsets kept small most of the time so axes rarely saturate
                write_reg(tcch_pkg::REG_OFFSET_X, offset_draw(phase == 4));
                write_reg(tcch_pkg::REG_OFFSET_Y, offset_draw(phase == 4));
                write_reg(tcch_pkg::REG_OFFSET_Z, offset_draw(phase == 4));
                write_reg(tcch_pkg::REG_SCALE_Y, 16'($urandom));
                write_reg(tcch_pkg::REG_SCALE_Z, 16'($urandom));
                write_reg(tcch_pkg::REG_PITCH_TRIM, 16'($urandom));
                write_reg(tcch_pkg::REG_ROLL_TRIM, 16'($urandom));
                write_reg(tcch_pkg::REG_DECLINATION,
                          16'($urandom_range(0, 36000) - 18000));
            end
            // run one phase flat out to hold a full pipe
            no_idle = (phase == 2);
            repeat (85) send_sample(any_sample());
            drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        off_x = 0; off_y = 0; off_z = 0;
        scl_y = 4096; scl_z = 4096;
        trim_p = 300; trim_r = 200; decl = 500;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_extremes();
        test_random_samples();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
